// ===== src/running_mean_variance_defines.svh =====
// Assertion macros shared by the running mean and variance RTL.
// No dependencies; included by the files that carry assertions.
`ifndef RUNNING_MEAN_VARIANCE_DEFINES_SVH
`define RUNNING_MEAN_VARIANCE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every rising edge outside reset.
`define RMV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// The expression must never be true outside reset.
`define RMV_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define RMV_ASSERT(label, clk, rst_n, prop)
`define RMV_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== src/rmv_pkg.sv =====
// Package for the running mean and variance block: widths, limits,
// payload types and the sequencer state type. No dependencies.
`default_nettype none

package rmv_pkg;

  // Word field widths on the ports.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned MEAN_W   = 32;
  localparam int unsigned VAR_W    = 63;

  // Internal widths of the statistics.
  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned COUNT_BITS  = 32;
  localparam int unsigned SUM_BITS    = 63;
  localparam int unsigned PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int unsigned ACC_BITS    = SUM_BITS + 2;
  localparam int unsigned DIV_BITS    = SUM_BITS + 1;
  localparam int unsigned ITER_BITS   = $clog2(DIV_BITS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [COUNT_W-1:0]  count_t;
  typedef logic signed [MEAN_W-1:0]   mean_t;
  typedef logic        [VAR_W-1:0]    var_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_MEAN_UPD,
    ST_DEV,
    ST_MUL,
    ST_ACC,
    ST_DIV_VAR,
    ST_RESULT
  } rmv_state_e;

endpackage

`default_nettype wire

// ===== src/rmv_if.sv =====
// Handshake interfaces for the sample input and the statistics output.
// Depends on rmv_pkg for the payload types.
`default_nettype none

interface rmv_in_if;
  import rmv_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmv_out_if;
  import rmv_pkg::*;

  logic   valid;
  logic   ready;
  count_t sample_count;
  mean_t  mean_value;
  var_t   variance_value;

  modport source (output valid, output sample_count, output mean_value,
                  output variance_value, input ready);
  modport sink   (input valid, input sample_count, input mean_value,
                  input variance_value, output ready);
endinterface

`default_nettype wire

// ===== src/running_mean_variance.sv =====
// Running mean and variance top level: sequencer, shared divider, datapath.
// Depends on rmv_pkg, the interfaces in rmv_if.sv and the assertion macros.
`default_nettype none

`include "running_mean_variance_defines.svh"

// Each sample word updates a saturating count, the running mean and the sum
// of squared deviations by Welford's recurrence, and yields one result word
// with the count, the mean and the population variance (sum / count, Q31.32,
// truncated). A sample passes through the mean division, the mean update,
// the deviation, the product, the sum update, the variance division and the
// result hand-over; the input is ready again once the result is registered.
// A single restoring divider produces one quotient bit per cycle and is used
// twice per sample: once for the mean step and once for the variance. The
// input is ready only while the sequencer is idle; a finished result waits in
// an output register, so the next sample is taken while that result is still
// unread. No clearing pass follows reset.
module running_mean_variance (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  rmv_in_if.sink         sample_i,
  rmv_out_if.source      result_o
);
  import rmv_pkg::*;

  rmv_state_e state_q, state_d;

  // Architectural statistics.
  logic [COUNT_BITS-1:0]  count_q, count_d;
  logic [SAMPLE_BITS-1:0] mean_q, mean_d;
  logic [SUM_BITS-1:0]    sum_q, sum_d;

  // Working registers of the current sample.
  logic [SAMPLE_BITS-1:0] x_q, x_d;
  logic [SAMPLE_BITS-1:0] m1_q, m1_d;
  logic                   neg1_q, neg1_d;
  logic [SAMPLE_BITS-1:0] m2_q, m2_d;
  logic                   negp_q, negp_d;
  logic [PROD_BITS-1:0]   prod_q, prod_d;

  // Shared divider registers.
  logic [COUNT_BITS-1:0]  rem_q, rem_d;
  logic [DIV_BITS-1:0]    quo_q, quo_d;
  logic [ITER_BITS-1:0]   iter_q, iter_d;

  // Output register.
  logic                   out_valid_q;
  count_t                 out_count_q;
  mean_t                  out_mean_q;
  var_t                   out_var_q;

  logic in_accept;
  logic out_free;
  logic out_load;

  logic [SAMPLE_BITS-1:0] x_in;
  logic [SAMPLE_BITS:0]   d1;
  logic [SAMPLE_BITS:0]   d1_neg;
  logic [SAMPLE_BITS:0]   d2;
  logic [SAMPLE_BITS:0]   d2_neg;

  logic [COUNT_BITS:0]    div_trial;
  logic [COUNT_BITS+1:0]  div_diff;
  logic                   div_ge;

  logic [ACC_BITS-1:0]    acc_sum;
  logic                   acc_sat;
  logic                   acc_ge;
  logic [SUM_BITS-1:0]    acc_diff;
  logic [SUM_BITS-1:0]    sum_new;

  assign in_accept = sample_i.valid && sample_i.ready;
  assign out_free  = !out_valid_q || result_o.ready;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (iter_q == ITER_BITS'(1)) begin
          state_d = ST_MEAN_UPD;
        end
      end
      ST_MEAN_UPD: state_d = ST_DEV;
      ST_DEV:      state_d = ST_MUL;
      ST_MUL:      state_d = ST_ACC;
      ST_ACC:      state_d = ST_DIV_VAR;
      ST_DIV_VAR: begin
        if (iter_q == ITER_BITS'(1)) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    sample_i.ready = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      ST_IDLE:   sample_i.ready = 1'b1;
      ST_RESULT: out_load       = out_free;
      default: begin
        sample_i.ready = 1'b0;
        out_load       = 1'b0;
      end
    endcase
  end

  // Deviation of the incoming sample from the old mean, as sign and size.
  assign x_in   = sample_i.sample[SAMPLE_BITS-1:0];
  assign d1     = {x_in[SAMPLE_BITS-1], x_in} - {mean_q[SAMPLE_BITS-1], mean_q};
  assign d1_neg = -d1;

  // Deviation of the stored sample from the new mean.
  assign d2     = {x_q[SAMPLE_BITS-1], x_q} - {mean_q[SAMPLE_BITS-1], mean_q};
  assign d2_neg = -d2;

  // One restoring division step against the count.
  assign div_trial = {rem_q, quo_q[DIV_BITS-1]};
  assign div_diff  = {1'b0, div_trial} - {2'b00, count_q};
  assign div_ge    = !div_diff[COUNT_BITS+1];

  // Sum update: add with saturation, or subtract with a floor at zero.
  assign acc_sum  = ACC_BITS'(sum_q) + ACC_BITS'(prod_q);
  assign acc_sat  = |acc_sum[ACC_BITS-1:SUM_BITS];
  assign acc_ge   = ACC_BITS'(prod_q) >= ACC_BITS'(sum_q);
  assign acc_diff = sum_q - prod_q[SUM_BITS-1:0];

  always_comb begin
    if (negp_q) begin
      sum_new = acc_ge ? '0 : acc_diff;
    end else begin
      sum_new = acc_sat ? SUM_MAX : acc_sum[SUM_BITS-1:0];
    end
  end

  // Datapath next values, steered by the sequencer state.
  always_comb begin
    count_d = count_q;
    mean_d  = mean_q;
    sum_d   = sum_q;
    x_d     = x_q;
    m1_d    = m1_q;
    neg1_d  = neg1_q;
    m2_d    = m2_q;
    negp_d  = negp_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    iter_d  = iter_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          x_d     = x_in;
          count_d = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
          neg1_d  = d1[SAMPLE_BITS];
          m1_d    = d1[SAMPLE_BITS] ? d1_neg[SAMPLE_BITS-1:0] : d1[SAMPLE_BITS-1:0];
          // The size goes in left-aligned so that its quotient ends up low.
          quo_d   = DIV_BITS'(d1[SAMPLE_BITS] ? d1_neg[SAMPLE_BITS-1:0]
                                              : d1[SAMPLE_BITS-1:0])
                    << (DIV_BITS - SAMPLE_BITS);
          rem_d   = '0;
          iter_d  = ITER_BITS'(SAMPLE_BITS);
        end
      end
      ST_DIV_MEAN, ST_DIV_VAR: begin
        rem_d  = div_ge ? div_diff[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
        quo_d  = {quo_q[DIV_BITS-2:0], div_ge};
        iter_d = iter_q - 1'b1;
      end
      ST_MEAN_UPD: begin
        // The step is truncated toward zero, so the mean cannot overshoot.
        mean_d = neg1_q ? mean_q - quo_q[SAMPLE_BITS-1:0]
                        : mean_q + quo_q[SAMPLE_BITS-1:0];
      end
      ST_DEV: begin
        m2_d   = d2[SAMPLE_BITS] ? d2_neg[SAMPLE_BITS-1:0] : d2[SAMPLE_BITS-1:0];
        negp_d = (neg1_q != d2[SAMPLE_BITS]) && (m1_q != '0) && (d2 != '0);
      end
      ST_MUL: begin
        prod_d = PROD_BITS'(m1_q) * PROD_BITS'(m2_q);
      end
      ST_ACC: begin
        sum_d  = sum_new;
        quo_d  = DIV_BITS'(sum_new);
        rem_d  = '0;
        iter_d = ITER_BITS'(DIV_BITS);
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // Control state and statistics, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      mean_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      mean_q  <= mean_d;
      sum_q   <= sum_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    m1_q   <= m1_d;
    neg1_q <= neg1_d;
    m2_q   <= m2_d;
    negp_q <= negp_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    iter_q <= iter_d;
    if (out_load) begin
      out_count_q <= COUNT_W'(count_q);
      out_mean_q  <= MEAN_W'(signed'(mean_q));
      out_var_q   <= VAR_W'(quo_q[SUM_BITS-1:0]);
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.sample_count   = out_count_q;
  assign result_o.mean_value     = out_mean_q;
  assign result_o.variance_value = out_var_q;

  // An accepted word always starts the mean division.
  `RMV_ASSERT(a_accept_starts_div, clk_i, rst_ni, in_accept |=> state_q == ST_DIV_MEAN)
  // The divider never works against a zero count.
  `RMV_ASSERT_NEVER(a_count_nonzero, clk_i, rst_ni, state_q != ST_IDLE && count_q == '0)
  // The partial remainder stays below the divisor.
  `RMV_ASSERT(a_rem_below_count, clk_i, rst_ni, (state_q == ST_DIV_MEAN || state_q == ST_DIV_VAR) |-> rem_q < count_q)
  // A division never runs out of steps before it hands over.
  `RMV_ASSERT_NEVER(a_iter_live, clk_i, rst_ni, (state_q == ST_DIV_MEAN || state_q == ST_DIV_VAR) && iter_q == '0)

endmodule

`default_nettype wire

// ===== test/running_mean_variance_checker.sv =====
`timescale 1ns / 1ps
// Checker for the running mean and variance block: predicts every result word.
// Compares each result with the prediction. Depends on rmv_pkg only.

module running_mean_variance_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            sample_valid_i,
  input  logic            sample_ready_i,
  input  rmv_pkg::sample_t sample_i,
  input  logic            result_valid_i,
  input  logic            result_ready_i,
  input  rmv_pkg::count_t sample_count_i,
  input  rmv_pkg::mean_t  mean_value_i,
  input  rmv_pkg::var_t   variance_value_i,
  output int unsigned     error_count_o,
  output int unsigned     pending_o
);
  import rmv_pkg::*;

  typedef struct packed {
    count_t count;
    mean_t  mean;
    var_t   variance;
  } stats_t;

  // Predicted statistics, oldest first.
  stats_t stats_q[$];

  // Own copy of the running statistics.
  count_t           run_count;
  mean_t            run_mean;
  logic [SUM_BITS-1:0] run_sum;

  int unsigned fail_total;

  // Welford update of the running statistics for one sample; returns the result word.
  function automatic stats_t welford_update(input sample_t x);
    longint      dev_old;
    longint      dev_new;
    longint      mean_step;
    longint      next_mean;
    logic [63:0] mag_old;
    logic [63:0] mag_new;
    logic [63:0] quot;
    logic [63:0] prod;
    logic [63:0] sum_wide;
    logic [63:0] sum_limit;
    logic        shrinks;
    stats_t      res;
    if (run_count != COUNT_MAX) begin
      run_count = run_count + 1'b1;
    end

    // The step towards the sample is truncated towards zero.
    dev_old   = longint'(x) - longint'(run_mean);
    mag_old   = (dev_old < 0) ? -dev_old : dev_old;
    quot      = mag_old / {32'd0, run_count};
    mean_step = longint'(quot);
    if (dev_old < 0) begin
      mean_step = -mean_step;
    end
    next_mean = longint'(run_mean) + mean_step;
    run_mean  = next_mean[MEAN_W-1:0];

    // Product of the deviations before and after the mean moved.
    dev_new   = longint'(x) - longint'(run_mean);
    mag_new   = (dev_new < 0) ? -dev_new : dev_new;
    prod      = mag_old * mag_new;
    shrinks   = ((dev_old < 0) != (dev_new < 0)) && (mag_old != 0) && (mag_new != 0);
    sum_wide  = {1'b0, run_sum};
    sum_limit = {1'b0, SUM_MAX};
    if (shrinks) begin
      run_sum = (prod >= sum_wide) ? '0 : run_sum - prod[SUM_BITS-1:0];
    end else if (prod >= sum_limit || (sum_limit - prod) < sum_wide) begin
      run_sum = SUM_MAX;
    end else begin
      run_sum = run_sum + prod[SUM_BITS-1:0];
    end

    sum_wide     = {1'b0, run_sum};
    quot         = sum_wide / {32'd0, run_count};
    res.count    = run_count;
    res.mean     = run_mean;
    res.variance = quot[VAR_W-1:0];
    return res;
  endfunction

  // Counts a failure and shows the first few of them.
  task automatic flag_error(input string what, input logic [63:0] want,
                            input logic [63:0] got);
    fail_total++;
    if (fail_total <= 10) begin
      $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Result words are checked before the sample word of the same edge is predicted,
  // since a result can never stem from a sample taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    stats_t want;
    if (!rst_ni) begin
      stats_q.delete();
      run_count     = '0;
      run_mean      = '0;
      run_sum       = '0;
      fail_total    = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (result_valid_i && result_ready_i) begin
        if (stats_q.size() == 0) begin
          flag_error("result word with nothing expected", '0, {32'd0, sample_count_i});
        end else begin
          want = stats_q.pop_front();
          if (sample_count_i !== want.count) begin
            flag_error("sample_count", 64'(want.count), 64'(sample_count_i));
          end
          if (mean_value_i !== want.mean) begin
            flag_error("mean_value", 64'(want.mean), 64'(mean_value_i));
          end
          if (variance_value_i !== want.variance) begin
            flag_error("variance_value", 64'(want.variance), 64'(variance_value_i));
          end
        end
      end
      if (sample_valid_i && sample_ready_i) begin
        stats_q.push_back(welford_update(sample_i));
      end
      error_count_o <= fail_total;
      pending_o     <= stats_q.size();
    end
  end

endmodule

// ===== test/running_mean_variance_test.sv =====
`timescale 1ns / 1ps
// Top of the running mean and variance testbench: clock, reset, sample words
// and result back-pressure. Depends on rmv_pkg, rmv_if.sv, the block and the checker.

module running_mean_variance_test;
  import rmv_pkg::*;

  // Span for which an unstalled sample occupies the block at the default widths.
  localparam int unsigned BLOCK_LATENCY  = 102;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef enum logic [1:0] {
    SINK_RANDOM,
    SINK_STEADY,
    SINK_HOLD
  } sink_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sink_mode_e  sink_mode = SINK_RANDOM;
  bit          src_idle  = 1'b0;
  int unsigned mismatch_count;
  int unsigned pending_words;
  int unsigned quiet_cycles;

  rmv_in_if  sample_ch ();
  rmv_out_if result_ch ();

  running_mean_variance u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch)
  );

  running_mean_variance_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_valid_i   (sample_ch.valid),
    .sample_ready_i   (sample_ch.ready),
    .sample_i         (sample_ch.sample),
    .result_valid_i   (result_ch.valid),
    .result_ready_i   (result_ch.ready),
    .sample_count_i   (result_ch.sample_count),
    .mean_value_i     (result_ch.mean_value),
    .variance_value_i (result_ch.variance_value),
    .error_count_o    (mismatch_count),
    .pending_o        (pending_words)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Moderate random sample: a random width keeps the sum of squares far from
  // saturation, and an occasional offset moves the mean about.
  function automatic sample_t random_sample();
    int unsigned       width;
    logic signed [31:0] spread;
    logic signed [31:0] offset;
    width  = $urandom_range(1, 24);
    spread = $urandom;
    spread = spread >>> (32 - width);
    offset = $urandom;
    offset = ($urandom_range(3) == 0) ? (offset >>> 9) : '0;
    return spread + offset;
  endfunction

  // Offers one sample word, with an optional gap first, and waits for acceptance.
  task automatic send_word(input sample_t value);
    int unsigned gap;
    if (src_idle && $urandom_range(99) < 23) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(10, 130) : $urandom_range(1, 3);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    do @(posedge clk_i); while (!(sample_ch.valid && sample_ch.ready));
  endtask

  // Random samples, now and then the same value several times over.
  task automatic send_random_words(input int unsigned total);
    sample_t     word;
    int unsigned sent;
    int unsigned runs;
    sent = 0;
    while (sent < total) begin
      word = random_sample();
      runs = ($urandom_range(7) == 0) ? $urandom_range(2, 6) : 1;
      repeat (runs) begin
        send_word(word);
        sent++;
      end
    end
  endtask

  // Stops offering and blocks until every predicted result word has been read.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
  endtask

  // Result back-pressure: random stalls, a stall-free stretch, or one long hold-off.
  initial begin
    int unsigned idle_left;
    int unsigned hold_left;
    bit          hold_started;
    idle_left       = 0;
    hold_left       = 0;
    hold_started    = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_mode == SINK_HOLD) begin
        if (!hold_started) begin
          hold_started = 1'b1;
          hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          result_ch.ready <= 1'b0;
        end else begin
          result_ch.ready <= 1'b1;
        end
      end else if (sink_mode == SINK_STEADY) begin
        result_ch.ready <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        result_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < 20) begin
        idle_left = ($urandom_range(15) == 0) ? $urandom_range(2, 6) : 0;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any word moving ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_ni && quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus and verdict.
  initial begin
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Opening corners: zero, one unit, plus and minus one, and small steps
    // that the truncated mean update rounds towards zero.
    src_idle = 1'b0;
    send_word(32'h0000_0000);
    send_word(32'h0001_0000);
    send_word(32'hFFFF_0000);
    send_word(32'h0000_0001);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0003);
    send_word(32'h0000_0002);
    send_word(32'h0000_7FFF);
    send_word(32'hFFFF_8000);
    send_word(32'h00FF_FFFF);
    send_word(32'hFF00_0000);
    send_word(32'h0000_0000);

    // Sender pauses until the block has handed back every result.
    wait_drained();

    src_idle = 1'b1;
    send_random_words(500);

    // A stretch with no idling on either side.
    src_idle  = 1'b0;
    sink_mode = SINK_STEADY;
    send_random_words(150);

    // The receiver holds off while samples keep coming, so the block fills up.
    sink_mode = SINK_HOLD;
    send_random_words(20);
    wait_drained();

    sink_mode = SINK_RANDOM;
    src_idle  = 1'b1;
    send_random_words(560);

    // Field extremes last, since they drive the sum of squares into saturation,
    // where it stays for the rest of the run.
    src_idle = 1'b0;
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);

    wait_drained();
    repeat (2 * BLOCK_LATENCY + 20) @(posedge clk_i);

    if (mismatch_count == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
